### hdl/uart_baud_modulation_calculator_assert.svh
// assertion macros for the uart baud and modulation calculator
`ifndef UART_BAUD_MODULATION_CALCULATOR_ASSERT_SVH
`define UART_BAUD_MODULATION_CALCULATOR_ASSERT_SVH

// same-cycle implication checked on every clock edge out of reset
`define UBMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked on every clock edge out of reset
`define UBMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ubmc_pkg.sv
// shared types and constants for the uart baud and modulation calculator
package ubmc_pkg;

    localparam int unsigned BAUD_W = 20;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned DIV_W = 10;
    localparam int unsigned MASK_W = 8;
    localparam int unsigned REM_W = 23;
    localparam int unsigned B100_W = 24;
    localparam int unsigned TICK_W = 14;
    localparam int unsigned X_W = 34;
    localparam int unsigned Y_W = 24;
    localparam int unsigned RECIP_W = 25;
    localparam int unsigned P_W = 49;
    localparam int unsigned Q_W = 11;
    localparam int unsigned SUM_W = 4;

    localparam logic [REM_W-1:0] SLOW_CLOCK_HZ = 23'd32768;
    localparam logic [REM_W-1:0] FAST_CLOCK_HZ = 23'd8000000;
    localparam logic [BAUD_W-1:0] SLOW_MAX_BAUD = 20'd9600;
    localparam logic [BAUD_W-1:0] BAUD_MIN = 20'd300;
    localparam logic [BAUD_W-1:0] BAUD_MAX = 20'd115200;
    localparam logic [6:0] ERR_SCALE = 7'd100;

    // fast clock 8000000 = 2^9 * 15625; divide by 15625 as multiply by
    // ceil(2^38 / 15625), exact for any 24-bit operand
    localparam int unsigned FAST_SHIFT = 9;
    localparam int unsigned SLOW_SHIFT = 15;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] RECIP_15625 = 25'd17592187;

    localparam logic [CODE_W-1:0] CH_N_LO = 8'h6e;
    localparam logic [CODE_W-1:0] CH_N_UP = 8'h4e;
    localparam logic [CODE_W-1:0] CH_P_LO = 8'h70;
    localparam logic [CODE_W-1:0] CH_P_UP = 8'h50;
    localparam logic [CODE_W-1:0] CH_O_LO = 8'h6f;
    localparam logic [CODE_W-1:0] CH_O_UP = 8'h4f;
    localparam logic [CODE_W-1:0] BITS_7 = 8'd7;
    localparam logic [CODE_W-1:0] BITS_8 = 8'd8;
    localparam logic [CODE_W-1:0] CH_7 = 8'h37;
    localparam logic [CODE_W-1:0] CH_8 = 8'h38;
    localparam logic [CODE_W-1:0] STOP_1 = 8'd1;
    localparam logic [CODE_W-1:0] STOP_2 = 8'd2;
    localparam logic [CODE_W-1:0] CH_1 = 8'h31;
    localparam logic [CODE_W-1:0] CH_2 = 8'h32;

    // classified request from the front end
    typedef struct packed {
        logic ok;
        logic slow;
        logic [BAUD_W-1:0] baud;
        logic pen;
        logic pev;
        logic eight;
        logic two;
    } req_t;

    // finished result
    typedef struct packed {
        logic ok;
        logic slow;
        logic [DIV_W-1:0] divider;
        logic [MASK_W-1:0] mask;
        logic pen;
        logic pev;
        logic eight;
        logic two;
    } res_t;

endpackage

### hdl/ubmc_front.sv
// front end: accepts requests, checks the codes and the rate range
module ubmc_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [ubmc_pkg::BAUD_W-1:0] baud_rate,
    input  logic [ubmc_pkg::CODE_W-1:0] parity_code,
    input  logic [ubmc_pkg::CODE_W-1:0] data_bits_code,
    input  logic [ubmc_pkg::CODE_W-1:0] stop_bits_code,
    output logic push,
    output ubmc_pkg::req_t push_req,
    input  logic q_full
);

    logic front_vld_reg, front_vld_next;
    ubmc_pkg::req_t front_req_reg;
    ubmc_pkg::req_t cls;
    logic accept;
    logic par_n, par_p, par_o, dat_7, dat_8, stp_1, stp_2, rate_ok;

    assign in_stall = front_vld_reg && q_full;
    assign accept = in_valid && !in_stall;
    assign push = front_vld_reg && !q_full;
    assign push_req = front_req_reg;

    // decode the frame codes
    always_comb
    begin
        par_n = (parity_code == ubmc_pkg::CH_N_LO) || (parity_code == ubmc_pkg::CH_N_UP);
        par_p = (parity_code == ubmc_pkg::CH_P_LO) || (parity_code == ubmc_pkg::CH_P_UP);
        par_o = (parity_code == ubmc_pkg::CH_O_LO) || (parity_code == ubmc_pkg::CH_O_UP);
        dat_7 = (data_bits_code == ubmc_pkg::BITS_7) || (data_bits_code == ubmc_pkg::CH_7);
        dat_8 = (data_bits_code == ubmc_pkg::BITS_8) || (data_bits_code == ubmc_pkg::CH_8);
        stp_1 = (stop_bits_code == ubmc_pkg::STOP_1) || (stop_bits_code == ubmc_pkg::CH_1);
        stp_2 = (stop_bits_code == ubmc_pkg::STOP_2) || (stop_bits_code == ubmc_pkg::CH_2);
        rate_ok = (baud_rate >= ubmc_pkg::BAUD_MIN) && (baud_rate <= ubmc_pkg::BAUD_MAX);
        cls.ok = rate_ok && (par_n || par_p || par_o) && (dat_7 || dat_8)
            && (stp_1 || stp_2);
        cls.slow = baud_rate <= ubmc_pkg::SLOW_MAX_BAUD;
        cls.baud = baud_rate;
        cls.pen = cls.ok && (par_p || par_o);
        cls.pev = cls.ok && par_p;
        cls.eight = cls.ok && dat_8;
        cls.two = cls.ok && stp_2;
    end

    // holding register occupancy
    always_comb
    begin
        if (accept)
        begin
            front_vld_next = 1'b1;
        end
        else if (push)
        begin
            front_vld_next = 1'b0;
        end
        else
        begin
            front_vld_next = front_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_vld_reg <= 1'b0;
        end
        else
        begin
            front_vld_reg <= front_vld_next;
        end
    end

    // classified payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_req_reg <= cls;
        end
    end

endmodule

### hdl/ubmc_queue.sv
// two-entry queue between front end and back end
module ubmc_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ubmc_pkg::req_t push_req,
    output logic full,
    output logic q_valid,
    output ubmc_pkg::req_t q_req,
    input  logic pop_ready
);

    ubmc_pkg::req_t entry_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic pop;

    assign full = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_req = entry_reg[rd_ptr_reg];
    assign pop = q_valid && pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

### hdl/ubmc_back.sv
// back end: pipelined divider and greedy modulation search
module ubmc_back (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  ubmc_pkg::req_t q_req,
    output logic pop_ready,
    output logic res_valid,
    output ubmc_pkg::res_t res,
    input  logic out_stall
);

    localparam int unsigned DIV_STAGES = ubmc_pkg::DIV_W;
    localparam int unsigned MOD_STEPS = ubmc_pkg::MASK_W;
    localparam int unsigned NSTAGE = 1 + DIV_STAGES + 3 * MOD_STEPS;

    typedef struct packed {
        ubmc_pkg::req_t req;
        logic [ubmc_pkg::B100_W-1:0] b100;
        logic [ubmc_pkg::REM_W-1:0] rem;
        logic [ubmc_pkg::DIV_W-1:0] quo;
        logic [ubmc_pkg::SUM_W-1:0] sum;
        logic [ubmc_pkg::MASK_W-1:0] mask;
        logic [ubmc_pkg::X_W-1:0] x0;
        logic [ubmc_pkg::X_W-1:0] x1;
        logic [ubmc_pkg::P_W-1:0] p0;
        logic [ubmc_pkg::P_W-1:0] p1;
    } work_t;

    logic vld_reg [NSTAGE];
    work_t wk_reg [NSTAGE];
    work_t wk_next [NSTAGE];
    logic advance;

    // one restoring divide step for quotient bit b
    function automatic work_t div_fn(input work_t w, input int unsigned b);
        work_t r;
        logic [ubmc_pkg::BAUD_W+DIV_STAGES-1:0] sh;
        begin
            r = w;
            sh = {{DIV_STAGES{1'b0}}, w.req.baud} << b;
            if ({{(ubmc_pkg::BAUD_W+DIV_STAGES-ubmc_pkg::REM_W){1'b0}}, w.rem} >= sh)
            begin
                r.rem = w.rem - sh[ubmc_pkg::REM_W-1:0];
                r.quo = w.quo | (ubmc_pkg::DIV_W'(1) << b);
            end
            return r;
        end
    endfunction

    // scaled tick products for step j
    function automatic work_t mul_fn(input work_t w, input int unsigned j);
        work_t r;
        logic [ubmc_pkg::TICK_W-1:0] ticks;
        logic [ubmc_pkg::B100_W+ubmc_pkg::TICK_W-1:0] prod;
        begin
            r = w;
            ticks = ubmc_pkg::TICK_W'(w.quo) * ubmc_pkg::TICK_W'(j + 1)
                + ubmc_pkg::TICK_W'(w.sum);
            prod = w.b100 * ticks;
            r.x0 = prod[ubmc_pkg::X_W-1:0];
            r.x1 = prod[ubmc_pkg::X_W-1:0] + ubmc_pkg::X_W'(w.b100);
            return r;
        end
    endfunction

    // reciprocal products for the fast clock
    function automatic work_t rec_fn(input work_t w);
        work_t r;
        begin
            r = w;
            r.p0 = w.x0[ubmc_pkg::FAST_SHIFT+ubmc_pkg::Y_W-1:ubmc_pkg::FAST_SHIFT]
                * ubmc_pkg::RECIP_15625;
            r.p1 = w.x1[ubmc_pkg::FAST_SHIFT+ubmc_pkg::Y_W-1:ubmc_pkg::FAST_SHIFT]
                * ubmc_pkg::RECIP_15625;
            return r;
        end
    endfunction

    // compare the two timing errors and take the bit when it helps
    function automatic work_t dec_fn(input work_t w, input int unsigned j);
        work_t r;
        logic [ubmc_pkg::Q_W-1:0] q0, q1;
        logic signed [ubmc_pkg::Q_W+1:0] d0, d1, t;
        logic [ubmc_pkg::Q_W+1:0] m0, m1;
        begin
            r = w;
            if (w.req.slow)
            begin
                q0 = w.x0[ubmc_pkg::SLOW_SHIFT+ubmc_pkg::Q_W-1:ubmc_pkg::SLOW_SHIFT];
                q1 = w.x1[ubmc_pkg::SLOW_SHIFT+ubmc_pkg::Q_W-1:ubmc_pkg::SLOW_SHIFT];
            end
            else
            begin
                q0 = w.p0[ubmc_pkg::RECIP_SHIFT+ubmc_pkg::Q_W-1:ubmc_pkg::RECIP_SHIFT];
                q1 = w.p1[ubmc_pkg::RECIP_SHIFT+ubmc_pkg::Q_W-1:ubmc_pkg::RECIP_SHIFT];
            end
            t = $signed((ubmc_pkg::Q_W+2)'(ubmc_pkg::ERR_SCALE) * (ubmc_pkg::Q_W+2)'(j + 1));
            d0 = $signed({2'b00, q0}) - t;
            d1 = $signed({2'b00, q1}) - t;
            m0 = d0[ubmc_pkg::Q_W+1] ? (ubmc_pkg::Q_W+2)'(-d0) : (ubmc_pkg::Q_W+2)'(d0);
            m1 = d1[ubmc_pkg::Q_W+1] ? (ubmc_pkg::Q_W+2)'(-d1) : (ubmc_pkg::Q_W+2)'(d1);
            if (m1 < m0)
            begin
                r.sum = w.sum + 4'd1;
                r.mask = w.mask | (ubmc_pkg::MASK_W'(1) << j);
            end
            return r;
        end
    endfunction

    // whole pipeline moves unless a finished result is held
    assign advance = !(vld_reg[NSTAGE-1] && out_stall);
    assign pop_ready = advance;

    // stage loading and per-stage work
    always_comb
    begin
        wk_next[0].req = q_req;
        wk_next[0].b100 = ubmc_pkg::B100_W'(q_req.baud) * ubmc_pkg::B100_W'(ubmc_pkg::ERR_SCALE);
        wk_next[0].rem = q_req.slow ? ubmc_pkg::SLOW_CLOCK_HZ : ubmc_pkg::FAST_CLOCK_HZ;
        wk_next[0].quo = '0;
        wk_next[0].sum = '0;
        wk_next[0].mask = '0;
        wk_next[0].x0 = '0;
        wk_next[0].x1 = '0;
        wk_next[0].p0 = '0;
        wk_next[0].p1 = '0;
        for (int unsigned b = 0; b < DIV_STAGES; b++)
        begin
            wk_next[1+b] = div_fn(wk_reg[b], DIV_STAGES - 1 - b);
        end
        for (int unsigned j = 0; j < MOD_STEPS; j++)
        begin
            wk_next[1+DIV_STAGES+3*j] = mul_fn(wk_reg[DIV_STAGES+3*j], j);
            wk_next[2+DIV_STAGES+3*j] = rec_fn(wk_reg[1+DIV_STAGES+3*j]);
            wk_next[3+DIV_STAGES+3*j] = dec_fn(wk_reg[2+DIV_STAGES+3*j], j);
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int unsigned s = 0; s < NSTAGE; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= q_valid;
            for (int unsigned s = 1; s < NSTAGE; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int unsigned s = 0; s < NSTAGE; s++)
            begin
                wk_reg[s] <= wk_next[s];
            end
        end
    end

    // result from the last stage, divider and mask zeroed for rejected requests
    always_comb
    begin
        res_valid = vld_reg[NSTAGE-1];
        res.ok = wk_reg[NSTAGE-1].req.ok;
        res.slow = wk_reg[NSTAGE-1].req.slow;
        res.divider = wk_reg[NSTAGE-1].req.ok ? wk_reg[NSTAGE-1].quo : '0;
        res.mask = wk_reg[NSTAGE-1].req.ok ? wk_reg[NSTAGE-1].mask : '0;
        res.pen = wk_reg[NSTAGE-1].req.pen;
        res.pev = wk_reg[NSTAGE-1].req.pev;
        res.eight = wk_reg[NSTAGE-1].req.eight;
        res.two = wk_reg[NSTAGE-1].req.two;
    end

endmodule

### hdl/uart_baud_modulation_calculator.sv
// top level of the uart baud divider and modulation calculator
//
// Takes one set-up request per transaction and returns one result per request, in order.
// Sustained rate is one request per clock while out_stall is low. A request passes through
// the front register and the queue, then a 35-stage back end made of a load stage, ten
// shift-subtract divider stages (one quotient bit each) and eight modulation steps of three
// stages each (tick product, reciprocal multiply for the 8 MHz clock, error compare); the
// last stage is the output register. The two-entry queue lets the front end keep taking
// requests while the back end holds a stalled result.
module uart_baud_modulation_calculator (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic [ubmc_pkg::BAUD_W-1:0] baud_rate,
    input  logic [ubmc_pkg::CODE_W-1:0] parity_code,
    input  logic [ubmc_pkg::CODE_W-1:0] data_bits_code,
    input  logic [ubmc_pkg::CODE_W-1:0] stop_bits_code,
    output logic out_valid,
    input  logic out_stall,
    output logic ok,
    output logic slow_clock_select,
    output logic [ubmc_pkg::DIV_W-1:0] divider,
    output logic [ubmc_pkg::MASK_W-1:0] modulation_mask,
    output logic parity_enable,
    output logic parity_even,
    output logic eight_data_bits,
    output logic two_stop_bits
);

`include "uart_baud_modulation_calculator_assert.svh"

    logic push, q_full, q_valid, pop_ready;
    ubmc_pkg::req_t push_req, q_req;
    ubmc_pkg::res_t res;

    ubmc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .baud_rate      (baud_rate),
        .parity_code    (parity_code),
        .data_bits_code (data_bits_code),
        .stop_bits_code (stop_bits_code),
        .push           (push),
        .push_req       (push_req),
        .q_full         (q_full)
    );

    ubmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .pop_ready (pop_ready)
    );

    ubmc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .pop_ready (pop_ready),
        .res_valid (out_valid),
        .res       (res),
        .out_stall (out_stall)
    );

    // result fields
    assign ok = res.ok;
    assign slow_clock_select = res.slow;
    assign divider = res.divider;
    assign modulation_mask = res.mask;
    assign parity_enable = res.pen;
    assign parity_even = res.pev;
    assign eight_data_bits = res.eight;
    assign two_stop_bits = res.two;

    // checks
    `UBMC_ASSERT_IMPLY(a_reject_zero, clk, rst_n, out_valid && !ok, divider == '0 && modulation_mask == '0 && !parity_enable && !parity_even && !eight_data_bits && !two_stop_bits, "rejected result carries nonzero fields")
    `UBMC_ASSERT_IMPLY(a_ok_divider, clk, rst_n, out_valid && ok, divider != '0, "accepted result has zero divider")
    `UBMC_ASSERT_IMPLY(a_even_needs_parity, clk, rst_n, out_valid && parity_even, parity_enable, "even parity without parity enable")
    `UBMC_ASSERT_NEXT(a_front_blocks_on_full, clk, rst_n, in_stall && !pop_ready, in_stall, "front released while queue stays full")

endmodule
